FILE: design/vzc_pkg.sv
package vzc_pkg;

    // value and byte widths
    localparam int VAL_W   = 64;
    localparam int NARW_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int GRP_W   = 7;
    localparam int CNT_W   = 4;

    // maximum encoded length per mode
    localparam logic [CNT_W-1:0] NARROW_BYTES = 4'd5;
    localparam logic [CNT_W-1:0] WIDE_BYTES   = 4'd10;

    // continuation flag
    localparam logic [BYTE_W-1:0] CONT_BIT = 8'h80;

    // input command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // result kind codes
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // configuration register indexes
    localparam logic REG_WIDE   = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ENC  = 2'b10
    } t_state;

    // sequencer to shift unit
    typedef struct packed {
        logic load;
        logic step;
    } t_enc_ctrl;

    // shift unit to sequencer
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              more;
    } t_enc_stat;

endpackage

FILE: design/vzc_enc_unit.sv
module vzc_enc_unit (
    input  logic                          i_clk,
    input  vzc_pkg::t_enc_ctrl            i_ctrl,
    input  logic [vzc_pkg::VAL_W-1:0]     i_z,
    output vzc_pkg::t_enc_stat            o_stat
);
    import vzc_pkg::*;

    logic [VAL_W-1:0] r_z;
    logic [VAL_W-1:0] n_z;
    logic             w_more;

    // more groups remain when anything sits above the low seven bits
    assign w_more = |r_z[VAL_W-1:GRP_W];

    // current byte with continuation flag
    assign o_stat.more     = w_more;
    assign o_stat.out_byte = {w_more, r_z[GRP_W-1:0]};

    // load a value or shift one group out per step
    always_comb begin
        n_z = r_z;
        if (i_ctrl.load) begin
            n_z = i_z;
        end else if (i_ctrl.step) begin
            n_z = r_z >> GRP_W;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z <= n_z;
    end

endmodule

FILE: design/varint_zigzag_codec.sv
// Base-128 varint codec with optional zigzag sign mapping, 32-bit or 64-bit mode.
// A decode request (s_axis_tuser = 1) takes one byte; it yields a value result only
// on a byte below 0x80 or on the 5th / 10th byte, the latter flagged unterminated.
// An encode request (s_axis_tuser = 0) occupies the block until its last byte is
// emitted (1 to 5 bytes, or 1 to 10 in 64-bit mode), since a single 7-bit shift unit
// releases one byte per cycle into the output register while the output is not
// stalled. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the
// user must write it only while the block is idle, as the block does not enforce this.
module varint_zigzag_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_wdata,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] value_in, [71:64] byte_in
    input  logic        s_axis_tuser,   // [0] cmd
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] byte_out, [71:8] value_out
    output logic [1:0]  m_axis_tuser,   // [0] kind, [1] unterminated
    output logic        m_axis_tlast    // last
);
    import vzc_pkg::*;

    // configuration
    logic r_wide;
    logic r_signed;

    // decode state
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] n_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // sequencer
    t_state r_state;
    t_state n_state;

    // output register
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_out_kind;
    logic              n_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic [BYTE_W-1:0] n_out_byte;
    logic [VAL_W-1:0]  r_out_value;
    logic [VAL_W-1:0]  n_out_value;
    logic              r_out_last;
    logic              n_out_last;
    logic              r_out_unt;
    logic              n_out_unt;

    // request fields
    logic [VAL_W-1:0]  w_value_in;
    logic [BYTE_W-1:0] w_byte_in;
    logic              w_cmd;
    logic              w_accept;
    logic              w_slot_free;

    // encode path
    logic [VAL_W-1:0]  w_z;
    logic [NARW_W-1:0] w_v32;
    t_enc_ctrl         w_ctrl;
    t_enc_stat         w_stat;

    // decode path
    logic [5:0]        w_shamt;
    logic [VAL_W-1:0]  w_grp;
    logic [VAL_W-1:0]  w_acc_new;
    logic [CNT_W-1:0]  w_cnt_new;
    logic [CNT_W-1:0]  w_limit;
    logic              w_done;
    logic [NARW_W-1:0] w_a32;
    logic [NARW_W-1:0] w_u32;
    logic [VAL_W-1:0]  w_dec_val;

    assign w_value_in = s_axis_tdata[VAL_W-1:0];
    assign w_byte_in  = s_axis_tdata[VAL_W+BYTE_W-1:VAL_W];
    assign w_cmd      = s_axis_tuser;

    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // zigzag map or width mask of the value to encode
    assign w_v32 = w_value_in[NARW_W-1:0];
    always_comb begin
        if (r_signed) begin
            if (r_wide) begin
                w_z = {w_value_in[VAL_W-2:0], 1'b0} ^ {VAL_W{w_value_in[VAL_W-1]}};
            end else begin
                w_z = {{(VAL_W-NARW_W){1'b0}},
                       {w_v32[NARW_W-2:0], 1'b0} ^ {NARW_W{w_v32[NARW_W-1]}}};
            end
        end else if (r_wide) begin
            w_z = w_value_in;
        end else begin
            w_z = {{(VAL_W-NARW_W){1'b0}}, w_v32};
        end
    end

    // single 7-bit shift unit of the encode path
    assign w_ctrl.load = w_accept && (w_cmd == CMD_ENCODE);
    assign w_ctrl.step = (r_state == ST_ENC) && w_slot_free;

    vzc_enc_unit u_enc (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_z    (w_z),
        .o_stat (w_stat)
    );

    // place the incoming group at its position
    assign w_shamt   = 6'(r_cnt * GRP_W);
    assign w_grp     = {{(VAL_W-GRP_W){1'b0}}, w_byte_in[GRP_W-1:0]} << w_shamt;
    always_comb begin
        w_acc_new = r_acc | w_grp;
        if (!r_wide) begin
            w_acc_new[VAL_W-1:NARW_W] = '0;
        end
    end
    assign w_cnt_new = r_cnt + 4'd1;
    assign w_limit   = r_wide ? WIDE_BYTES : NARROW_BYTES;
    assign w_done    = !w_byte_in[BYTE_W-1] || (w_cnt_new >= w_limit);

    // inverse zigzag and extension of the decoded value
    assign w_a32 = w_acc_new[NARW_W-1:0];
    assign w_u32 = (w_a32 >> 1) ^ {NARW_W{w_a32[0]}};
    always_comb begin
        if (r_signed) begin
            if (r_wide) begin
                w_dec_val = (w_acc_new >> 1) ^ {VAL_W{w_acc_new[0]}};
            end else begin
                w_dec_val = {{(VAL_W-NARW_W){w_u32[NARW_W-1]}}, w_u32};
            end
        end else begin
            w_dec_val = w_acc_new;
        end
    end

    // sequencer, decode state and output register
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_unt   = r_out_unt;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_cmd == CMD_ENCODE) begin
                        n_state = ST_ENC;
                    end else if (w_done) begin
                        n_acc       = '0;
                        n_cnt       = '0;
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_VALUE;
                        n_out_byte  = '0;
                        n_out_value = w_dec_val;
                        n_out_last  = 1'b1;
                        n_out_unt   = w_byte_in[BYTE_W-1];
                    end else begin
                        n_acc = w_acc_new;
                        n_cnt = w_cnt_new;
                    end
                end
            end
            ST_ENC: begin
                if (w_ctrl.step) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_BYTE;
                    n_out_byte  = w_stat.out_byte;
                    n_out_value = '0;
                    n_out_last  = !w_stat.more;
                    n_out_unt   = 1'b0;
                    if (!w_stat.more) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wide      <= 1'b1;
            r_signed    <= 1'b0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDE:   r_wide   <= i_cfg_wdata;
                    REG_SIGNED: r_signed <= i_cfg_wdata;
                    default:    r_wide   <= r_wide;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_byte  <= n_out_byte;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_unt   <= n_out_unt;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_value, r_out_byte};
    assign m_axis_tuser  = {r_out_unt, r_out_kind};
    assign m_axis_tlast  = r_out_last;

    // partial decode never holds as many bytes as the widest limit
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < WIDE_BYTES)
        else $error("decode byte count out of range");

    // no request taken while encode bytes are still going out
    a_busy_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ENC) |-> !s_axis_tready)
        else $error("request accepted during encode");

    // final encode byte returns the sequencer to idle
    a_enc_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_ENC) && w_ctrl.step && !w_stat.more) |=> (r_state == ST_IDLE))
        else $error("encode did not finish on last byte");

    // a decoded value is always the last result of its request
    a_dec_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_VALUE)) |-> r_out_last)
        else $error("decode result without last");

    // an encode result never carries the unterminated flag
    a_enc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_BYTE)) |-> !r_out_unt)
        else $error("unterminated flag on encode byte");

endmodule
